### rtl/fpt_pkg.sv
`default_nettype none

package fpt_pkg;

   // Default geometry of the panel
   localparam int unsigned NUM_SWITCHES_DEF = 8;
   localparam int unsigned NUM_PAGES_DEF    = 8;

   // Register widths and reset values
   localparam int unsigned MAP_W         = 64;
   localparam int unsigned MAP_SEL_W     = $clog2(MAP_W);
   localparam int unsigned LOCKOUT_W     = 8;
   localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = LOCKOUT_W'(10);

   // CSR write channel
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = MAP_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCAN_ENABLE    = 2'd0,
      CSR_LED_TOGGLE_MAP = 2'd1,
      CSR_LOCKOUT_TICKS  = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

### rtl/fpt_channels.sv
`default_nettype none

// Switch level beat
interface fpt_req_if #(
   parameter int unsigned NUM_SWITCHES = fpt_pkg::NUM_SWITCHES_DEF
);
   logic                    valid;
   logic                    ready;
   logic [NUM_SWITCHES+1:0] raw_levels;

   modport source (output valid, output raw_levels, input ready);
   modport sink   (input valid, input raw_levels, output ready);
endinterface

// Result beat
interface fpt_rsp_if #(
   parameter int unsigned NUM_SWITCHES = fpt_pkg::NUM_SWITCHES_DEF,
   parameter int unsigned NUM_PAGES    = fpt_pkg::NUM_PAGES_DEF
);
   localparam int unsigned PAGE_W = $clog2(NUM_PAGES);

   logic                    valid;
   logic                    ready;
   logic [NUM_SWITCHES+1:0] led_lamps;
   logic [PAGE_W-1:0]       active_page;
   logic [PAGE_W-1:0]       event_page;
   logic [NUM_SWITCHES-1:0] pressed_mask;
   logic [NUM_SWITCHES-1:0] released_mask;
   logic [NUM_SWITCHES-1:0] toggle_bits;

   modport source (output valid, output led_lamps, output active_page, output event_page,
                   output pressed_mask, output released_mask, output toggle_bits,
                   input ready);
   modport sink   (input valid, input led_lamps, input active_page, input event_page,
                   input pressed_mask, input released_mask, input toggle_bits,
                   output ready);
endinterface

// Register write beat
interface fpt_csr_if;
   logic                               valid;
   logic                               ready;
   logic [fpt_pkg::CSR_IDX_W-1:0]      index;
   logic [fpt_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/footswitch_page_toggle_panel_core.sv
// Path: an accepted beat waits in the input register and then moves into the result
// register once that is free, which holds it until the result is taken.
// Throughput: one beat per cycle; while a result waits, the input register takes one
// more beat and then holds the input off until the result is taken.
// Reset (synchronous, active high) releases all switches, clears lockout, page,
// toggle bits and LEDs, disables scanning and sets the lockout reload to 10 ticks.
`default_nettype none

module footswitch_page_toggle_panel_core #(
   parameter int unsigned NUM_SWITCHES = fpt_pkg::NUM_SWITCHES_DEF,
   parameter int unsigned NUM_PAGES    = fpt_pkg::NUM_PAGES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   fpt_req_if.sink    req_bus,
   fpt_rsp_if.source  rsp_bus,
   fpt_csr_if.sink    csr_bus
);

   localparam int unsigned PAGE_W = $clog2(NUM_PAGES);
   localparam int unsigned LVL_W  = NUM_SWITCHES + 2;
   localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(NUM_PAGES - 1);

   // Configuration registers
   logic                              scan_enable_ff;
   logic [fpt_pkg::MAP_W-1:0]         toggle_map_ff;
   logic [fpt_pkg::LOCKOUT_W-1:0]     lockout_ticks_ff;

   // Panel state
   logic [LVL_W-1:0]                       prev_levels_ff, prev_levels_in;
   logic [fpt_pkg::LOCKOUT_W-1:0]          lockout_ff, lockout_in;
   logic [PAGE_W-1:0]                      page_ff, page_in;
   logic [NUM_PAGES-1:0][NUM_SWITCHES-1:0] tog_store_ff, tog_store_in;
   logic [LVL_W-1:0]                       lamps_ff, lamps_in;

   // Input and result stages
   logic                    in_valid_ff;
   logic [LVL_W-1:0]        in_levels_ff;
   logic                    out_valid_ff;
   logic [NUM_SWITCHES-1:0] pressed_in, released_in, toggle_bits_in;
   logic [PAGE_W-1:0]       event_page_ff;
   logic [NUM_SWITCHES-1:0] pressed_ff, released_ff, toggle_bits_ff;

   logic out_free;
   logic step;
   logic accept;

   // Handshake: the input register advances into the result register
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign step          = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_enable_ff   <= 1'b0;
         toggle_map_ff    <= '0;
         lockout_ticks_ff <= fpt_pkg::LOCKOUT_RESET;
      end else if (csr_bus.valid) begin
         case (fpt_pkg::csr_index_type'(csr_bus.index))
            fpt_pkg::CSR_SCAN_ENABLE:    scan_enable_ff   <= csr_bus.data[0];
            fpt_pkg::CSR_LED_TOGGLE_MAP: toggle_map_ff    <= csr_bus.data;
            fpt_pkg::CSR_LOCKOUT_TICKS:  lockout_ticks_ff <= csr_bus.data[fpt_pkg::LOCKOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_levels_ff <= req_bus.raw_levels;
      end
   end

   // Tick logic
   fpt_tick #(
      .NUM_SWITCHES (NUM_SWITCHES),
      .NUM_PAGES    (NUM_PAGES)
   ) u_tick (
      .levels           (in_levels_ff),
      .scan_enable      (scan_enable_ff),
      .toggle_map       (toggle_map_ff),
      .lockout_ticks    (lockout_ticks_ff),
      .prev_levels      (prev_levels_ff),
      .lockout          (lockout_ff),
      .page             (page_ff),
      .tog_store        (tog_store_ff),
      .lamps            (lamps_ff),
      .next_prev_levels (prev_levels_in),
      .next_lockout     (lockout_in),
      .next_page        (page_in),
      .next_tog_store   (tog_store_in),
      .next_lamps       (lamps_in),
      .pressed          (pressed_in),
      .released         (released_in),
      .toggle_bits      (toggle_bits_in)
   );

   // Panel state updates once per processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_levels_ff <= '1;
         lockout_ff     <= '0;
         page_ff        <= '0;
         tog_store_ff   <= '0;
         lamps_ff       <= '0;
      end else if (step) begin
         prev_levels_ff <= prev_levels_in;
         lockout_ff     <= lockout_in;
         page_ff        <= page_in;
         tog_store_ff   <= tog_store_in;
         lamps_ff       <= lamps_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         event_page_ff  <= page_ff;
         pressed_ff     <= pressed_in;
         released_ff    <= released_in;
         toggle_bits_ff <= toggle_bits_in;
      end
   end

   // LEDs and page are the live state, which only moves on the beat that loads the result
   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.led_lamps     = lamps_ff;
   assign rsp_bus.active_page   = page_ff;
   assign rsp_bus.event_page    = event_page_ff;
   assign rsp_bus.pressed_mask  = pressed_ff;
   assign rsp_bus.released_mask = released_ff;
   assign rsp_bus.toggle_bits   = toggle_bits_ff;

   // Page saturates within the page range
   a_page_range: assert property (@(posedge clock) disable iff (reset)
      page_ff <= LAST_PAGE)
      else $error("page out of range");

   // A switch cannot be pressed and released in the same tick
   a_press_release_disjoint: assert property (@(posedge clock) disable iff (reset)
      step |-> ((pressed_in & released_in) == '0))
      else $error("press and release on the same switch");

   // A running lockout counts down by one and reports no events
   a_lockout_countdown: assert property (@(posedge clock) disable iff (reset)
      (step && scan_enable_ff && (lockout_ff != '0)) |=>
         ((lockout_ff == $past(lockout_ff) - 1'b1) && (pressed_ff == '0)
          && (released_ff == '0)))
      else $error("lockout did not count down cleanly");

   // Page only moves on a processed beat
   a_page_moves_on_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(page_ff))
      else $error("page changed without a beat");

endmodule

`default_nettype wire

### rtl/fpt_tick.sv
`default_nettype none

// Next-state logic for one scan tick: edge detect, toggle latch, LEDs, paging and lockout.
module fpt_tick #(
   parameter int unsigned NUM_SWITCHES = fpt_pkg::NUM_SWITCHES_DEF,
   parameter int unsigned NUM_PAGES    = fpt_pkg::NUM_PAGES_DEF,
   localparam int unsigned PAGE_W      = $clog2(NUM_PAGES),
   localparam int unsigned LVL_W       = NUM_SWITCHES + 2
) (
   input  wire logic [LVL_W-1:0]                       levels,
   input  wire logic                                   scan_enable,
   input  wire logic [fpt_pkg::MAP_W-1:0]              toggle_map,
   input  wire logic [fpt_pkg::LOCKOUT_W-1:0]          lockout_ticks,
   input  wire logic [LVL_W-1:0]                       prev_levels,
   input  wire logic [fpt_pkg::LOCKOUT_W-1:0]          lockout,
   input  wire logic [PAGE_W-1:0]                      page,
   input  wire logic [NUM_PAGES-1:0][NUM_SWITCHES-1:0] tog_store,
   input  wire logic [LVL_W-1:0]                       lamps,
   output logic      [LVL_W-1:0]                       next_prev_levels,
   output logic      [fpt_pkg::LOCKOUT_W-1:0]          next_lockout,
   output logic      [PAGE_W-1:0]                      next_page,
   output logic      [NUM_PAGES-1:0][NUM_SWITCHES-1:0] next_tog_store,
   output logic      [LVL_W-1:0]                       next_lamps,
   output logic      [NUM_SWITCHES-1:0]                pressed,
   output logic      [NUM_SWITCHES-1:0]                released,
   output logic      [NUM_SWITCHES-1:0]                toggle_bits
);

   localparam int unsigned IDX_RAW_W = $clog2(NUM_PAGES * NUM_SWITCHES);
   localparam int unsigned IDX_W     = (IDX_RAW_W > fpt_pkg::MAP_SEL_W) ?
                                       IDX_RAW_W : fpt_pkg::MAP_SEL_W + 1;
   localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(NUM_PAGES - 1);
   localparam int unsigned PG_DN = NUM_SWITCHES;
   localparam int unsigned PG_UP = NUM_SWITCHES + 1;

   // Map bit for a switch on a page; map indexes past the map are momentary
   function automatic logic follows(input logic [fpt_pkg::MAP_W-1:0] map,
                                    input logic [PAGE_W-1:0] pg,
                                    input int unsigned sw);
      logic [IDX_W-1:0] idx;
      idx = IDX_W'(pg) * IDX_W'(NUM_SWITCHES) + IDX_W'(sw);
      follows = (idx < IDX_W'(fpt_pkg::MAP_W)) && map[idx[fpt_pkg::MAP_SEL_W-1:0]];
   endfunction

   logic                    scan;
   logic [LVL_W-1:0]        changed;
   logic [NUM_SWITCHES-1:0] cur_tog;
   logic [NUM_SWITCHES-1:0] new_tog;
   logic [NUM_SWITCHES-1:0] refresh_tog;
   logic [PAGE_W-1:0]       mid_page;
   logic                    moved;

   always_comb begin
      // Edges are seen only when scanning and out of lockout
      scan     = scan_enable && (lockout == '0);
      changed  = scan ? (levels ^ prev_levels) : '0;
      pressed  = changed[NUM_SWITCHES-1:0] & ~levels[NUM_SWITCHES-1:0];
      released = changed[NUM_SWITCHES-1:0] & levels[NUM_SWITCHES-1:0];

      // Toggle latch on the page in force
      cur_tog = tog_store[page];
      new_tog = cur_tog ^ pressed;

      // Command switch LEDs
      next_lamps = lamps;
      for (int unsigned i = 0; i < NUM_SWITCHES; i++) begin
         if (pressed[i]) begin
            next_lamps[i] = follows(toggle_map, page, i) ? new_tog[i] : 1'b1;
         end else if (released[i] && !follows(toggle_map, page, i)) begin
            next_lamps[i] = 1'b0;
         end
      end

      // Page down, then page up, both saturating
      mid_page = page;
      moved    = 1'b0;
      if (changed[PG_DN]) begin
         if (!levels[PG_DN]) begin
            next_lamps[PG_DN] = 1'b1;
            if (page != '0) begin
               mid_page = page - 1'b1;
               moved    = 1'b1;
            end
         end else begin
            next_lamps[PG_DN] = 1'b0;
         end
      end
      next_page = mid_page;
      if (changed[PG_UP]) begin
         if (!levels[PG_UP]) begin
            next_lamps[PG_UP] = 1'b1;
            if (mid_page != LAST_PAGE) begin
               next_page = mid_page + 1'b1;
               moved     = 1'b1;
            end
         end else begin
            next_lamps[PG_UP] = 1'b0;
         end
      end

      // Page move refreshes every switch LED from the final page
      refresh_tog = (next_page == page) ? new_tog : tog_store[next_page];
      if (moved) begin
         for (int unsigned i = 0; i < NUM_SWITCHES; i++) begin
            next_lamps[i] = follows(toggle_map, next_page, i) && refresh_tog[i];
         end
      end

      next_tog_store       = tog_store;
      next_tog_store[page] = new_tog;
      toggle_bits          = new_tog;

      // Lockout counter and last scanned levels
      if (!scan_enable) begin
         next_lockout = lockout;
      end else if (lockout != '0) begin
         next_lockout = lockout - 1'b1;
      end else if (changed != '0) begin
         next_lockout = lockout_ticks;
      end else begin
         next_lockout = '0;
      end
      next_prev_levels = scan ? levels : prev_levels;
   end

endmodule

`default_nettype wire
